/* src/irc_pkg.sv */
// Shared types and constants of the image row and column projection core.
// Used by the controller, the datapath and the top level; depends on nothing.
package irc_pkg;

  // Field widths fixed by the stream format.
  localparam int SUM_BITS    = 27;
  localparam int POS_W       = 9;
  localparam int OUT_TDATA_W = ((POS_W + SUM_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_DIM_W  = 10;
  localparam int CFG_CH_W   = 3;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS = 2'd2;

  localparam logic [CFG_DIM_W-1:0] ROWS_RST     = 10'd512;
  localparam logic [CFG_DIM_W-1:0] COLS_RST     = 10'd512;
  localparam logic [CFG_CH_W-1:0]  CHANNELS_RST = 3'd1;

  // Request and result codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;  // latch the request, RAM read issued
    logic calc;    // RAM data valid: update sums and counters
    logic emit;    // move the pending result into the output register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic produce;   // the request in calc yields a result
    logic out_free;  // the output register can take a result this cycle
  } ctrl_status_t;

endpackage

/* src/image_row_column_projection_core.sv */
// Row and column projection core. Uses irc_pkg, irc_ctrl, irc_datapath, irc_ram.
// A request is taken in the idle state, which issues the RAM read of its column
// sum; calc updates the sum, and a request that yields a result then waits in
// emit until the output register is free. The read-modify-write on the single
// column sum RAM sets the request rate: no request is taken before the last is
// done. Reset clears counters, row sum and config, but not the column RAM.
module image_row_column_projection_core #(
  parameter int MAX_ROWS     = 512,
  parameter int MAX_COLS     = 512,
  parameter int MAX_CHANNELS = 4,
  parameter int PIXEL_BITS   = 16,
  localparam int IN_TDATA_W  = ((PIXEL_BITS + irc_pkg::POS_W + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes: index 0 rows, 1 columns, 2 channels per pixel.
  input  logic                               cfg_we_i,
  input  logic [irc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [irc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Request stream.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]              s_axis_tdata_i,  // pixel_value, column_index
  input  logic                               s_axis_tuser_i,  // op
  // Result stream.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [irc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,  // position_index, sum_value
  output logic                               m_axis_tuser_o,  // result_kind
  output logic                               m_axis_tlast_o   // frame_done
);
  import irc_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  logic                       res_kind;
  logic [POS_W-1:0]           res_pos;
  logic signed [SUM_BITS-1:0] res_sum;

  // The controller only sequences: take a request, compute, hand the result on.
  irc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath owns the data state, including the output register, so a finished
  // result can wait there while the next request is already being taken.
  irc_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_op_i     (s_axis_tuser_i),
    .s_pixel_i  (s_axis_tdata_i[PIXEL_BITS-1:0]),
    .s_col_i    (s_axis_tdata_i[PIXEL_BITS +: POS_W]),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_kind_o   (res_kind),
    .m_pos_o    (res_pos),
    .m_sum_o    (res_sum),
    .m_last_o   (m_axis_tlast_o)
  );

  // Pack the result; bits above the sum are zero padding.
  assign m_axis_tdata_o = OUT_TDATA_W'({res_sum, res_pos});
  assign m_axis_tuser_o = res_kind;

  // A taken request blocks the input until its processing is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while the previous one is in progress");

  // Handing over a result always leaves a valid output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> m_axis_tvalid_o)
    else $error("emitted result did not reach the output register");

  // A result is only handed over when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten while a result waits");

  // Column reads never close a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == KIND_COL)) |-> !m_axis_tlast_o)
    else $error("column read flagged as frame end");

endmodule

/* src/irc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module irc_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/irc_ctrl.sv */
// Controller state machine of the projection core.
// Depends on irc_pkg for the command and status structs.
module irc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  irc_pkg::ctrl_status_t status_i,
  output irc_pkg::ctrl_cmd_t    cmd_o
);
  import irc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = status_i.produce ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/irc_datapath.sv */
// Datapath of the projection core: configuration, position counters, row
// accumulator, column sum RAM and output register. Depends on irc_pkg, irc_ram.
module irc_datapath #(
  parameter int MAX_ROWS     = 512,
  parameter int MAX_COLS     = 512,
  parameter int MAX_CHANNELS = 4,
  parameter int PIXEL_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [irc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [irc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  irc_pkg::ctrl_cmd_t                  cmd_i,
  output irc_pkg::ctrl_status_t               status_o,
  input  logic                                s_op_i,
  input  logic signed [PIXEL_BITS-1:0]        s_pixel_i,
  input  logic [irc_pkg::POS_W-1:0]           s_col_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic                                m_kind_o,
  output logic [irc_pkg::POS_W-1:0]           m_pos_o,
  output logic signed [irc_pkg::SUM_BITS-1:0] m_sum_o,
  output logic                                m_last_o
);
  import irc_pkg::*;

  localparam int RP_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CP_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HP_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RL_W  = ($clog2(MAX_ROWS + 1) > CFG_DIM_W) ? $clog2(MAX_ROWS + 1) : CFG_DIM_W;
  localparam int CL_W  = ($clog2(MAX_COLS + 1) > CFG_DIM_W) ? $clog2(MAX_COLS + 1) : CFG_DIM_W;
  localparam int HL_W  = ($clog2(MAX_CHANNELS + 1) > CFG_CH_W) ?
                         $clog2(MAX_CHANNELS + 1) : CFG_CH_W;
  localparam int EXT_W = (PIXEL_BITS > SUM_BITS) ? PIXEL_BITS : SUM_BITS;
  localparam int CX_W  = ((CP_W > POS_W) ? CP_W : POS_W) + 1;
  localparam int RX_W  = (RP_W > POS_W) ? RP_W : POS_W;

  // Configuration registers.
  logic [CFG_DIM_W-1:0] rows_q, cols_q;
  logic [CFG_CH_W-1:0]  chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ROWS_RST;
      cols_q  <= COLS_RST;
      chans_q <= CHANNELS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROWS:     rows_q  <= cfg_data_i;
        REG_COLS:     cols_q  <= cfg_data_i;
        REG_CHANNELS: chans_q <= cfg_data_i[CFG_CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits: zero acts as one, values above the maximum clamp.
  logic [RL_W-1:0] row_lim;
  logic [CL_W-1:0] col_lim;
  logic [HL_W-1:0] chan_lim;

  always_comb begin
    if (rows_q == '0) row_lim = RL_W'(1);
    else if (RL_W'(rows_q) > RL_W'(MAX_ROWS)) row_lim = RL_W'(MAX_ROWS);
    else row_lim = RL_W'(rows_q);

    if (cols_q == '0) col_lim = CL_W'(1);
    else if (CL_W'(cols_q) > CL_W'(MAX_COLS)) col_lim = CL_W'(MAX_COLS);
    else col_lim = CL_W'(cols_q);

    if (chans_q == '0) chan_lim = HL_W'(1);
    else if (HL_W'(chans_q) > HL_W'(MAX_CHANNELS)) chan_lim = HL_W'(MAX_CHANNELS);
    else chan_lim = HL_W'(chans_q);
  end

  // Request capture.
  logic signed [EXT_W-1:0] pix_ext;
  logic [CX_W-1:0]         col_ext;
  logic                    op_q, col_ok_q;
  logic [SUM_BITS-1:0]     val_q;
  logic [POS_W-1:0]        col_idx_q;

  assign pix_ext = EXT_W'($signed(s_pixel_i));
  assign col_ext = CX_W'(s_col_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= s_op_i;
      val_q     <= pix_ext[SUM_BITS-1:0];
      col_idx_q <= s_col_i;
      col_ok_q  <= (col_ext < CX_W'(MAX_COLS));
    end
  end

  // Position counters and row accumulator.
  logic [RP_W-1:0]     row_pos_q, row_pos_d;
  logic [CP_W-1:0]     col_pos_q, col_pos_d;
  logic [HP_W-1:0]     ch_pos_q, ch_pos_d;
  logic [SUM_BITS-1:0] row_acc_q, row_acc_d;
  logic                row_last, col_last, chan_last;

  assign row_last  = (RL_W'(row_pos_q) + RL_W'(1)) >= row_lim;
  assign col_last  = (CL_W'(col_pos_q) + CL_W'(1)) >= col_lim;
  assign chan_last = (HL_W'(ch_pos_q) + HL_W'(1)) >= chan_lim;

  // Column sum store, read while the request is taken, written in calc.
  logic [CP_W-1:0]     raddr;
  logic [SUM_BITS-1:0] rdata, wdata;
  logic                we;

  assign raddr = (s_op_i == OP_READ) ? col_ext[CP_W-1:0] : col_pos_q;
  assign we    = cmd_i.calc && (op_q == OP_PIXEL);
  assign wdata = ((row_pos_q == '0) && (ch_pos_q == '0)) ? val_q : rdata + val_q;

  irc_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (col_pos_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    ch_pos_d  = ch_pos_q;
    row_acc_d = ((col_pos_q == '0) && (ch_pos_q == '0)) ? val_q : row_acc_q + val_q;
    if (chan_last) begin
      ch_pos_d = '0;
      if (col_last) begin
        col_pos_d = '0;
        row_pos_d = row_last ? '0 : row_pos_q + RP_W'(1);
      end else begin
        col_pos_d = col_pos_q + CP_W'(1);
      end
    end else begin
      ch_pos_d = ch_pos_q + HP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
      ch_pos_q  <= '0;
      row_acc_q <= '0;
    end else if (we) begin
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
      ch_pos_q  <= ch_pos_d;
      row_acc_q <= row_acc_d;
    end
  end

  // Pending result, captured in calc.
  logic [RX_W-1:0]     row_ext;
  logic                res_kind_q, res_last_q;
  logic [POS_W-1:0]    res_pos_q;
  logic [SUM_BITS-1:0] res_sum_q;

  assign row_ext = RX_W'(row_pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      if (op_q == OP_READ) begin
        res_kind_q <= KIND_COL;
        res_pos_q  <= col_idx_q;
        res_sum_q  <= col_ok_q ? rdata : '0;
        res_last_q <= 1'b0;
      end else begin
        res_kind_q <= KIND_ROW;
        res_pos_q  <= row_ext[POS_W-1:0];
        res_sum_q  <= row_acc_d;
        res_last_q <= row_last;
      end
    end
  end

  // Output register.
  logic m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_kind_o <= res_kind_q;
      m_pos_o  <= res_pos_q;
      m_sum_o  <= res_sum_q;
      m_last_o <= res_last_q;
    end
  end

  assign m_tvalid_o        = m_valid_q;
  assign status_o.produce  = (op_q == OP_READ) || (chan_last && col_last);
  assign status_o.out_free = !m_valid_q || m_tready_i;

endmodule
